[design/mmtu_pkg.sv]
// Package for the machine-mode trap unit: request codes, CSR addresses,
// masks, cause codes and the structs passed between modules. No dependencies.
`default_nettype none

package mmtu_pkg;

  typedef enum logic [2:0] {
    REQ_EXEC     = 3'd0,
    REQ_CSR_RD   = 3'd1,
    REQ_CSR_WR   = 3'd2,
    REQ_SET_PEND = 3'd3,
    REQ_CLR_PEND = 3'd4
  } mmtu_req_e;

  typedef enum logic [2:0] {
    OUT_RETIRED     = 3'd0,
    OUT_NOT_RETIRED = 3'd1,
    OUT_FETCH_FAULT = 3'd2,
    OUT_ILLEGAL     = 3'd3,
    OUT_DATA_FAULT  = 3'd4
  } mmtu_outcome_e;

  typedef enum logic [1:0] {
    IRQ_SW  = 2'd0,
    IRQ_TIM = 2'd1,
    IRQ_EXT = 2'd2
  } mmtu_irq_e;

  localparam logic [11:0] CSR_MSTATUS    = 12'h300;
  localparam logic [11:0] CSR_MISA       = 12'h301;
  localparam logic [11:0] CSR_MIE        = 12'h304;
  localparam logic [11:0] CSR_MTVEC      = 12'h305;
  localparam logic [11:0] CSR_MCOUNTEREN = 12'h306;
  localparam logic [11:0] CSR_MSCRATCH   = 12'h340;
  localparam logic [11:0] CSR_MEPC       = 12'h341;
  localparam logic [11:0] CSR_MCAUSE     = 12'h342;
  localparam logic [11:0] CSR_MTVAL      = 12'h343;
  localparam logic [11:0] CSR_MIP        = 12'h344;
  localparam logic [11:0] CSR_MCYCLE     = 12'hB00;
  localparam logic [11:0] CSR_MCYCLEH    = 12'hB80;
  localparam logic [11:0] CSR_MINSTRET   = 12'hB02;
  localparam logic [11:0] CSR_MINSTRETH  = 12'hB82;

  localparam logic [12:0] MSTATUS_RESET  = 13'h1800;
  localparam logic [12:0] MSTATUS_MASK   = 13'h1888;
  localparam logic [11:0] IRQ_MASK       = 12'h888;
  localparam logic [31:0] MISA_VALUE     = 32'h4000_1010;
  localparam logic [31:0] MCOUNTEREN_VAL = 32'd7;

  localparam logic [3:0] CAUSE_MISALIGN    = 4'd0;
  localparam logic [3:0] CAUSE_FETCH_FAULT = 4'd1;
  localparam logic [3:0] CAUSE_ILLEGAL     = 4'd2;
  localparam logic [3:0] CAUSE_SW_IRQ      = 4'd3;
  localparam logic [3:0] CAUSE_LOAD_FAULT  = 4'd5;
  localparam logic [3:0] CAUSE_STORE_FAULT = 4'd7;
  localparam logic [3:0] CAUSE_TIM_IRQ     = 4'd7;
  localparam logic [3:0] CAUSE_EXT_IRQ     = 4'd11;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] pc_now;
    logic [31:0] pc_after;
    logic [2:0]  exec_outcome;
    logic        is_store;
    logic [11:0] csr_index;
    logic [31:0] csr_value;
    logic [1:0]  irq_source;
  } mmtu_req_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        trap_taken;
    logic [3:0]  trap_cause;
    logic        trap_is_interrupt;
    logic [31:0] read_data;
    logic        retired;
  } mmtu_rsp_t;

  typedef struct packed {
    logic        mie;
    logic [31:0] mtvec;
    logic [2:0]  irq_act;
  } mmtu_csr_view_t;

  typedef struct packed {
    logic        trap;
    logic [3:0]  cause;
    logic        is_int;
    logic [31:0] save_pc;
    logic        retire;
  } mmtu_trap_ctl_t;

  function automatic logic [11:0] irq_bit(logic [1:0] src);
    logic [11:0] bit_mask;
    case (src)
      IRQ_SW:  bit_mask = 12'h008;
      IRQ_TIM: bit_mask = 12'h080;
      IRQ_EXT: bit_mask = 12'h800;
      default: bit_mask = 12'h000;
    endcase
    return bit_mask;
  endfunction

endpackage

`default_nettype wire

[design/mmtu_if.sv]
// Valid/ready channel interfaces for trap unit requests and responses.
// Standalone; no package dependency.
`default_nettype none

interface mmtu_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [31:0] pc_now;
  logic [31:0] pc_after;
  logic [2:0]  exec_outcome;
  logic        is_store;
  logic [11:0] csr_index;
  logic [31:0] csr_value;
  logic [1:0]  irq_source;

  modport source (
    output valid, req_type, pc_now, pc_after, exec_outcome, is_store, csr_index,
           csr_value, irq_source,
    input  ready
  );
  modport sink (
    input  valid, req_type, pc_now, pc_after, exec_outcome, is_store, csr_index,
           csr_value, irq_source,
    output ready
  );
endinterface

interface mmtu_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic        trap_taken;
  logic [3:0]  trap_cause;
  logic        trap_is_interrupt;
  logic [31:0] read_data;
  logic        retired;

  modport source (
    output valid, next_pc, trap_taken, trap_cause, trap_is_interrupt, read_data,
           retired,
    input  ready
  );
  modport sink (
    input  valid, next_pc, trap_taken, trap_cause, trap_is_interrupt, read_data,
           retired,
    output ready
  );
endinterface

`default_nettype wire

[design/mmtu_trap_ctrl.sv]
// Trap decision: misaligned pc, faults, interrupt priority and vector target.
// Depends on mmtu_pkg.
`default_nettype none

module mmtu_trap_ctrl (
  input  mmtu_pkg::mmtu_req_t      req_i,
  input  mmtu_pkg::mmtu_csr_view_t view_i,
  output mmtu_pkg::mmtu_trap_ctl_t ctl_o,
  output logic [31:0]              next_pc_o
);

  mmtu_pkg::mmtu_trap_ctl_t ctl;
  logic [31:0]              base_pc;

  always_comb begin
    ctl     = '0;
    base_pc = req_i.pc_now;
    if (req_i.req_type == mmtu_pkg::REQ_EXEC) begin
      base_pc = req_i.pc_after;
      if (req_i.pc_now[1:0] != 2'b00) begin
        ctl.trap    = 1'b1;
        ctl.cause   = mmtu_pkg::CAUSE_MISALIGN;
        ctl.save_pc = req_i.pc_now;
      end else begin
        case (req_i.exec_outcome)
          mmtu_pkg::OUT_RETIRED: begin
            ctl.retire = 1'b1;
            if (view_i.mie && (view_i.irq_act != 3'b000)) begin
              ctl.trap    = 1'b1;
              ctl.is_int  = 1'b1;
              ctl.save_pc = req_i.pc_after;
              if (view_i.irq_act[2]) begin
                ctl.cause = mmtu_pkg::CAUSE_EXT_IRQ;
              end else if (view_i.irq_act[1]) begin
                ctl.cause = mmtu_pkg::CAUSE_TIM_IRQ;
              end else begin
                ctl.cause = mmtu_pkg::CAUSE_SW_IRQ;
              end
            end
          end
          mmtu_pkg::OUT_FETCH_FAULT: begin
            ctl.trap    = 1'b1;
            ctl.cause   = mmtu_pkg::CAUSE_FETCH_FAULT;
            ctl.save_pc = req_i.pc_now;
          end
          mmtu_pkg::OUT_ILLEGAL: begin
            ctl.trap    = 1'b1;
            ctl.cause   = mmtu_pkg::CAUSE_ILLEGAL;
            ctl.save_pc = req_i.pc_now;
          end
          mmtu_pkg::OUT_DATA_FAULT: begin
            ctl.trap    = 1'b1;
            ctl.cause   = req_i.is_store ? mmtu_pkg::CAUSE_STORE_FAULT
                                         : mmtu_pkg::CAUSE_LOAD_FAULT;
            ctl.save_pc = req_i.pc_now;
          end
          default: ;
        endcase
      end
    end
  end

  // vectored mode offsets by four per cause, less one for the mode bit
  always_comb begin
    next_pc_o = base_pc;
    if (ctl.trap) begin
      if (view_i.mtvec[0]) begin
        next_pc_o = view_i.mtvec + {26'd0, ctl.cause, 2'b00} - 32'd1;
      end else begin
        next_pc_o = view_i.mtvec;
      end
    end
  end

  assign ctl_o = ctl;

endmodule

`default_nettype wire

[design/mmtu_csr_file.sv]
// Machine-mode CSR state, read mux, masked writes, pending lines and counters.
// Depends on mmtu_pkg.
`default_nettype none

module mmtu_csr_file (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  mmtu_pkg::mmtu_req_t      req_i,
  input  mmtu_pkg::mmtu_trap_ctl_t ctl_i,
  output mmtu_pkg::mmtu_csr_view_t view_o,
  output logic [31:0]              rdata_o
);

  logic [12:0] mstatus_q, mstatus_d;
  logic [11:0] mie_q, mie_d;
  logic [11:0] mip_q, mip_d;
  logic [31:0] mtvec_q, mtvec_d;
  logic [31:0] mscratch_q, mscratch_d;
  logic [31:0] mepc_q, mepc_d;
  logic [31:0] mcause_q, mcause_d;
  logic [31:0] mtval_q, mtval_d;
  logic [63:0] mcycle_q, mcycle_d;
  logic [63:0] minstret_q, minstret_d;
  logic [11:0] src_mask;
  logic [11:0] irq_act;
  logic [31:0] csr_rd;

  assign src_mask = mmtu_pkg::irq_bit(req_i.irq_source);
  assign irq_act  = mip_q & mie_q & mmtu_pkg::IRQ_MASK;

  always_comb begin
    mstatus_d  = mstatus_q;
    mie_d      = mie_q;
    mip_d      = mip_q;
    mtvec_d    = mtvec_q;
    mscratch_d = mscratch_q;
    mepc_d     = mepc_q;
    mcause_d   = mcause_q;
    mtval_d    = mtval_q;
    mcycle_d   = mcycle_q;
    minstret_d = minstret_q;
    if (en_i) begin
      case (req_i.req_type)
        mmtu_pkg::REQ_EXEC: begin
          if (ctl_i.retire) begin
            mcycle_d   = mcycle_q + 64'd1;
            minstret_d = minstret_q + 64'd1;
          end
          if (ctl_i.trap) begin
            // keep MPP, move MIE into MPIE, clear MIE
            mstatus_d        = '0;
            mstatus_d[12:11] = mstatus_q[12:11];
            mstatus_d[7]     = mstatus_q[3];
            mcause_d         = {ctl_i.is_int, 27'd0, ctl_i.cause};
            mepc_d           = ctl_i.save_pc;
          end
        end
        mmtu_pkg::REQ_CSR_WR: begin
          unique case (req_i.csr_index)
            mmtu_pkg::CSR_MSTATUS: mstatus_d = (mstatus_q & ~mmtu_pkg::MSTATUS_MASK)
                                   | (req_i.csr_value[12:0] & mmtu_pkg::MSTATUS_MASK);
            mmtu_pkg::CSR_MIE:     mie_d = (mie_q & ~mmtu_pkg::IRQ_MASK)
                                   | (req_i.csr_value[11:0] & mmtu_pkg::IRQ_MASK);
            mmtu_pkg::CSR_MIP:     mip_d = (mip_q & ~mmtu_pkg::IRQ_MASK)
                                   | (req_i.csr_value[11:0] & mmtu_pkg::IRQ_MASK);
            mmtu_pkg::CSR_MTVEC:     mtvec_d = req_i.csr_value;
            mmtu_pkg::CSR_MSCRATCH:  mscratch_d = req_i.csr_value;
            mmtu_pkg::CSR_MEPC:      mepc_d = req_i.csr_value;
            mmtu_pkg::CSR_MCAUSE:    mcause_d = req_i.csr_value;
            mmtu_pkg::CSR_MTVAL:     mtval_d = req_i.csr_value;
            mmtu_pkg::CSR_MCYCLE:    mcycle_d[31:0] = req_i.csr_value;
            mmtu_pkg::CSR_MCYCLEH:   mcycle_d[63:32] = req_i.csr_value;
            mmtu_pkg::CSR_MINSTRET:  minstret_d[31:0] = req_i.csr_value;
            mmtu_pkg::CSR_MINSTRETH: minstret_d[63:32] = req_i.csr_value;
            default: ;
          endcase
        end
        mmtu_pkg::REQ_SET_PEND: mip_d = mip_q | src_mask;
        mmtu_pkg::REQ_CLR_PEND: mip_d = mip_q & ~src_mask;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mstatus_q  <= mmtu_pkg::MSTATUS_RESET;
      mie_q      <= '0;
      mip_q      <= '0;
      mtvec_q    <= '0;
      mscratch_q <= '0;
      mepc_q     <= '0;
      mcause_q   <= '0;
      mtval_q    <= '0;
      mcycle_q   <= '0;
      minstret_q <= '0;
    end else begin
      mstatus_q  <= mstatus_d;
      mie_q      <= mie_d;
      mip_q      <= mip_d;
      mtvec_q    <= mtvec_d;
      mscratch_q <= mscratch_d;
      mepc_q     <= mepc_d;
      mcause_q   <= mcause_d;
      mtval_q    <= mtval_d;
      mcycle_q   <= mcycle_d;
      minstret_q <= minstret_d;
    end
  end

  always_comb begin
    unique case (req_i.csr_index)
      mmtu_pkg::CSR_MSTATUS:    csr_rd = {19'd0, mstatus_q};
      mmtu_pkg::CSR_MISA:       csr_rd = mmtu_pkg::MISA_VALUE;
      mmtu_pkg::CSR_MIE:        csr_rd = {20'd0, mie_q};
      mmtu_pkg::CSR_MTVEC:      csr_rd = mtvec_q;
      mmtu_pkg::CSR_MCOUNTEREN: csr_rd = mmtu_pkg::MCOUNTEREN_VAL;
      mmtu_pkg::CSR_MSCRATCH:   csr_rd = mscratch_q;
      mmtu_pkg::CSR_MEPC:       csr_rd = mepc_q;
      mmtu_pkg::CSR_MCAUSE:     csr_rd = mcause_q;
      mmtu_pkg::CSR_MTVAL:      csr_rd = mtval_q;
      mmtu_pkg::CSR_MIP:        csr_rd = {20'd0, mip_q};
      mmtu_pkg::CSR_MCYCLE:     csr_rd = mcycle_q[31:0];
      mmtu_pkg::CSR_MCYCLEH:    csr_rd = mcycle_q[63:32];
      mmtu_pkg::CSR_MINSTRET:   csr_rd = minstret_q[31:0];
      mmtu_pkg::CSR_MINSTRETH:  csr_rd = minstret_q[63:32];
      default:                  csr_rd = '0;
    endcase
  end

  assign rdata_o        = (req_i.req_type == mmtu_pkg::REQ_CSR_RD) ? csr_rd : 32'd0;
  assign view_o.mie     = mstatus_q[3];
  assign view_o.mtvec   = mtvec_q;
  assign view_o.irq_act = {irq_act[11], irq_act[7], irq_act[3]};

endmodule

`default_nettype wire

[design/machine_mode_trap_unit_core.sv]
// Top level of the machine-mode trap unit: input register, CSR file, trap
// decision and result register. Depends on mmtu_pkg, mmtu_if, mmtu_csr_file,
// mmtu_trap_ctrl.
//
//   channel | dir | handshake     | payload
//   req_i   | in  | valid / ready | request type, pcs, outcome, CSR index/value, irq
//   rsp_o   | out | valid / ready | next pc, trap flags and cause, read data, retired
//
// One request per cycle unless rsp_o stalls; responses come from the result register.
// The CSR state updates as a request moves from the input to the result register,
// so the next request sees it with no gap.
// Reset clears the CSR state to its reset values and empties both registers.
// A stalled response holds the result register; the input register keeps
// taking a request while it moves on in the same cycle.
`default_nettype none

module machine_mode_trap_unit_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  mmtu_req_if.sink   req_i,
  mmtu_rsp_if.source rsp_o
);

  logic                     in_valid_q;
  mmtu_pkg::mmtu_req_t      in_q;
  mmtu_pkg::mmtu_req_t      in_d;
  logic                     out_valid_q;
  mmtu_pkg::mmtu_rsp_t      out_q;
  mmtu_pkg::mmtu_rsp_t      out_d;
  logic                     advance;
  logic                     in_fire;
  mmtu_pkg::mmtu_csr_view_t view;
  mmtu_pkg::mmtu_trap_ctl_t ctl;
  logic [31:0]              next_pc;
  logic [31:0]              rdata;

  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;
  assign in_fire     = req_i.valid && req_i.ready;

  assign in_d.req_type     = req_i.req_type;
  assign in_d.pc_now       = req_i.pc_now;
  assign in_d.pc_after     = req_i.pc_after;
  assign in_d.exec_outcome = req_i.exec_outcome;
  assign in_d.is_store     = req_i.is_store;
  assign in_d.csr_index    = req_i.csr_index;
  assign in_d.csr_value    = req_i.csr_value;
  assign in_d.irq_source   = req_i.irq_source;

  mmtu_csr_file u_csr_file (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .req_i   (in_q),
    .ctl_i   (ctl),
    .view_o  (view),
    .rdata_o (rdata)
  );

  mmtu_trap_ctrl u_trap_ctrl (
    .req_i     (in_q),
    .view_i    (view),
    .ctl_o     (ctl),
    .next_pc_o (next_pc)
  );

  assign out_d.next_pc           = next_pc;
  assign out_d.trap_taken        = ctl.trap;
  assign out_d.trap_cause        = ctl.cause;
  assign out_d.trap_is_interrupt = ctl.is_int;
  assign out_d.read_data         = rdata;
  assign out_d.retired           = ctl.retire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= in_d;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign rsp_o.valid             = out_valid_q;
  assign rsp_o.next_pc           = out_q.next_pc;
  assign rsp_o.trap_taken        = out_q.trap_taken;
  assign rsp_o.trap_cause        = out_q.trap_cause;
  assign rsp_o.trap_is_interrupt = out_q.trap_is_interrupt;
  assign rsp_o.read_data         = out_q.read_data;
  assign rsp_o.retired           = out_q.retired;

endmodule

`default_nettype wire

[design/mmtu_checker.sv]
// Port-level checks for the machine-mode trap unit, bound to the top level.
// Depends on machine_mode_trap_unit_core and mmtu_if.
`default_nettype none

module mmtu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic        trap_taken_i,
  input logic [3:0]  trap_cause_i,
  input logic        trap_is_interrupt_i,
  input logic [31:0] read_data_i,
  input logic        retired_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped before transfer");

  a_int_is_trap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && trap_is_interrupt_i |-> trap_taken_i)
    else $error("interrupt flagged without a trap");

  a_cause_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !trap_taken_i |-> trap_cause_i == 4'd0)
    else $error("nonzero cause without a trap");

  a_retire_trap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && retired_i && trap_taken_i |-> trap_is_interrupt_i)
    else $error("retired instruction took an exception");

  a_read_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && read_data_i != 32'd0 |-> !trap_taken_i && !retired_i)
    else $error("read data on an execute response");

endmodule

bind machine_mode_trap_unit_core mmtu_checker u_mmtu_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .rsp_valid_i         (rsp_o.valid),
  .rsp_ready_i         (rsp_o.ready),
  .trap_taken_i        (rsp_o.trap_taken),
  .trap_cause_i        (rsp_o.trap_cause),
  .trap_is_interrupt_i (rsp_o.trap_is_interrupt),
  .read_data_i         (rsp_o.read_data),
  .retired_i           (rsp_o.retired)
);

`default_nettype wire
